@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define DEQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ rtl/deq_pkg.sv @@
// Types and constants shared by the deque block and its checker.
`default_nettype none

package deq_pkg;

	localparam int CMD_W       = 3;
	localparam int FIELD_W     = 64;
	localparam int OCC_W       = 5;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 144;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * FIELD_W + OCC_W + 2 + ST_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY      = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4,
		CMD_REVERSE    = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Per-beat side information carried next to the slot RAM read data.
	typedef struct packed {
		logic             hit_front;
		logic             hit_back;
		logic             empty;
		logic             full;
		logic [OCC_W-1:0] occ;
		status_t          status;
	} meta_t;

endpackage

`default_nettype wire

@@ rtl/deq_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue held in a ring of RAM slots.
// Commands arrive on the slave stream (s_tvalid/s_tready/s_tdata): query,
// push back, push front, pop front, pop back, reverse or clear, with a word
// for pushes. Each command yields exactly one result beat on the master
// stream (m_tvalid/m_tready/m_tdata) with the front and back words (0 when
// empty), the occupancy, empty and full flags and a status: underflow for a
// pop of an empty deque, overflow for a push into a full one.
// Head index, count and a direction flag are updated in the cycle a command
// is accepted; the slot RAM is written and both ends are read in that same
// cycle. A result passes through the registered RAM read and then the
// output register before it leaves on the master stream. One
// command is taken every cycle while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its beat and one more
// command is taken into the read stage; after that s_tready drops.
// Reset clears head, count, direction and all valid flags. The slot RAM is
// not cleared: an end word is only read from a slot that was written.
`default_nettype none

module double_ended_queue #(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// command[2:0], push_value[66:3], zero pad[71:67]
	input  wire logic [deq_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// front_value[63:0], back_value[127:64], occupancy[132:128], is_empty[133],
	// is_full[134], status[136:135], zero pad[143:137]
	output logic      [deq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int AW1 = AW + 1;
	localparam int CW  = $clog2(CAPACITY + 1);

	// Ring state
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	// Input decode
	deq_pkg::cmd_t        cmd;
	logic [WORD_BITS-1:0] push_word;
	logic                 s_acc;

	// Next state and RAM access
	logic [AW-1:0]          head_n;
	logic [CW-1:0]          count_n;
	logic                   rev_n;
	deq_pkg::status_t       status_n;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          head_inc;
	logic [AW-1:0]          head_dec;
	logic [AW:0]            end_sum;
	logic [AW-1:0]          end_pos;
	logic [AW:0]            last_sum;
	logic [AW-1:0]          last_pos;
	logic [AW-1:0]          front_addr;
	logic [AW-1:0]          back_addr;
	logic                   full_q;
	logic                   empty_q;
	deq_pkg::meta_t         meta_n;

	// Read stage and output register
	logic                   valid_s1;
	deq_pkg::meta_t         meta_s1;
	logic [WORD_BITS-1:0]   push_s1;
	logic [WORD_BITS-1:0]   rdata_front;
	logic [WORD_BITS-1:0]   rdata_back;
	logic [WORD_BITS-1:0]   front_word;
	logic [WORD_BITS-1:0]   back_word;
	logic                   s2_load;
	logic                   valid_s2;
	logic [deq_pkg::OUT_TDATA_W-1:0] tdata_s2;

	assign cmd       = deq_pkg::cmd_t'(s_tdata[deq_pkg::CMD_W-1:0]);
	assign push_word = s_tdata[deq_pkg::CMD_W +: WORD_BITS];

	assign s2_load  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s2_load;
	assign s_acc    = s_tvalid && s_tready;

	assign full_q  = (count_q == CW'(CAPACITY));
	assign empty_q = (count_q == '0);

	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;

	// Slot just past the physical end; only used while not full
	assign end_sum = {1'b0, head_q} + AW1'(count_q);
	assign end_pos = (end_sum >= AW1'(CAPACITY)) ? AW'(end_sum - AW1'(CAPACITY))
	                                             : AW'(end_sum);

	always_comb begin
		head_n    = head_q;
		count_n   = count_q;
		rev_n     = rev_q;
		status_n  = deq_pkg::ST_OK;
		ram_we    = 1'b0;
		ram_waddr = end_pos;
		unique case (cmd) inside
			deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
				if (full_q) begin
					status_n = deq_pkg::ST_OVERFLOW;
				end else begin
					ram_we  = 1'b1;
					count_n = count_q + 1'b1;
					// Direction flag swaps which physical end is logical back
					if ((cmd == deq_pkg::CMD_PUSH_BACK) != rev_q) begin
						ram_waddr = end_pos;
					end else begin
						head_n    = head_dec;
						ram_waddr = head_dec;
					end
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
				if (empty_q) begin
					status_n = deq_pkg::ST_UNDERFLOW;
				end else begin
					count_n = count_q - 1'b1;
					if ((cmd == deq_pkg::CMD_POP_FRONT) != rev_q) begin
						head_n = head_inc;
					end
				end
			end
			deq_pkg::CMD_REVERSE: begin
				rev_n = !rev_q;
			end
			deq_pkg::CMD_CLEAR: begin
				head_n  = '0;
				count_n = '0;
				rev_n   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Physical last slot after the command; meaningless when empty
	assign last_sum = {1'b0, head_n} + AW1'(count_n) - AW1'(1);
	assign last_pos = (last_sum >= AW1'(CAPACITY)) ? AW'(last_sum - AW1'(CAPACITY))
	                                               : AW'(last_sum);

	assign front_addr = rev_n ? last_pos : head_n;
	assign back_addr  = rev_n ? head_n : last_pos;

	// Forward the word being written when an end reads the same slot
	always_comb begin
		meta_n.hit_front = ram_we && (ram_waddr == front_addr);
		meta_n.hit_back  = ram_we && (ram_waddr == back_addr);
		meta_n.empty     = (count_n == '0);
		meta_n.full      = (count_n == CW'(CAPACITY));
		meta_n.occ       = deq_pkg::OCC_W'(count_n);
		meta_n.status    = status_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (s_acc) begin
			head_q  <= head_n;
			count_q <= count_n;
			rev_q   <= rev_n;
		end
	end

	deq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CAPACITY)
	) u_deq_ram (
		.clk     (clk),
		.we      (s_acc && ram_we),
		.waddr   (ram_waddr),
		.wdata   (push_word),
		.re      (s_acc),
		.raddr_a (front_addr),
		.raddr_b (back_addr),
		.rdata_a (rdata_front),
		.rdata_b (rdata_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (s2_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			meta_s1 <= meta_n;
			push_s1 <= push_word;
		end
	end

	always_comb begin
		front_word = meta_s1.hit_front ? push_s1 : rdata_front;
		back_word  = meta_s1.hit_back ? push_s1 : rdata_back;
		if (meta_s1.empty) begin
			front_word = '0;
			back_word  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			tdata_s2 <= {{deq_pkg::OUT_PAD_W{1'b0}}, meta_s1.status, meta_s1.full,
			             meta_s1.empty, meta_s1.occ, deq_pkg::FIELD_W'(back_word),
			             deq_pkg::FIELD_W'(front_word)};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;

endmodule

`default_nettype wire

@@ rtl/deq_chk.sv @@
// Port-level checker for the deque block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module deq_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [deq_pkg::FIELD_W-1:0] front;
	logic [deq_pkg::FIELD_W-1:0] back;
	logic [deq_pkg::OCC_W-1:0]   occ;
	logic                        empty;
	logic                        full;
	logic [deq_pkg::ST_W-1:0]    status;

	assign front  = m_tdata[63:0];
	assign back   = m_tdata[127:64];
	assign occ    = m_tdata[132:128];
	assign empty  = m_tdata[133];
	assign full   = m_tdata[134];
	assign status = m_tdata[136:135];

	// An empty deque shows zero words and zero occupancy
	`DEQ_ASSERT(a_empty_zero, clk, arst_n, m_tvalid && empty |-> occ == '0 && front == '0 && back == '0, "empty result with nonzero fields")

	// Underflow only on an empty deque, overflow only on a full one
	`DEQ_ASSERT_NEVER(a_status_flags, clk, arst_n, m_tvalid && ((status == deq_pkg::ST_UNDERFLOW && !empty) || (status == deq_pkg::ST_OVERFLOW && !full)), "status disagrees with flags")

	// A single stored word is both front and back
	`DEQ_ASSERT(a_single_word, clk, arst_n, m_tvalid && occ == 5'd1 && !full |-> front == back, "single word differs at the two ends")

	// Hold a stalled beat
	`DEQ_ASSERT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")

endmodule

bind double_ended_queue deq_chk u_deq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/double_ended_queue_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed and random command streams.
module double_ended_queue_test;
	import deq_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int WORD_BITS    = 64;
	localparam int HEAD_W       = $clog2(CAPACITY);
	localparam int IDLE_PERCENT = 7;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RESET_CYCLES = 12;

	// command code with no meaning; the block answers it like a query
	localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

	// result beat layout
	localparam int FRONT_LO  = 0;
	localparam int BACK_LO   = FIELD_W;
	localparam int OCC_LO    = 2 * FIELD_W;
	localparam int EMPTY_BIT = OCC_LO + OCC_W;
	localparam int FULL_BIT  = EMPTY_BIT + 1;
	localparam int STATUS_LO = FULL_BIT + 1;

	typedef struct {
		logic [FIELD_W-1:0] front;
		logic [FIELD_W-1:0] back;
		logic [OCC_W-1:0]   occ;
		logic               empty;
		logic               full;
		status_t            status;
	} deque_view_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// predicted deque contents
	logic [WORD_BITS-1:0] ring_words [CAPACITY];
	logic [HEAD_W-1:0]    ring_head;
	logic [OCC_W-1:0]     ring_count;
	logic                 ring_reversed;

	deque_view_t expected_views [$];
	bit          idling_on = 1'b1;
	int unsigned commands_sent, views_checked, mismatches;
	int unsigned underflows, overflows, full_views, empty_views;
	int unsigned stall_cycles;

	double_ended_queue #(
		.CAPACITY (CAPACITY),
		.WORD_BITS(WORD_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin : clock_gen
		forever #6 clk = ~clk;
	end

	// Update the predicted deque with one command and return what the block must report.
	function automatic deque_view_t apply_command(input logic [CMD_W-1:0] op,
			input logic [WORD_BITS-1:0] word);
		deque_view_t          view;
		logic [HEAD_W-1:0]    tail_pos;
		logic [WORD_BITS-1:0] first_word;
		logic [WORD_BITS-1:0] last_word;
		view.status = ST_OK;
		first_word  = '0;
		last_word   = '0;
		case (op)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (ring_count == CAPACITY) begin
					view.status = ST_OVERFLOW;
				end else if ((op == CMD_PUSH_BACK) != ring_reversed) begin
					tail_pos             = ring_head + ring_count[HEAD_W-1:0];
					ring_words[tail_pos] = word;
					ring_count           = ring_count + 1'b1;
				end else begin
					ring_head             = ring_head - 1'b1;
					ring_words[ring_head] = word;
					ring_count            = ring_count + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (ring_count == 0) begin
					view.status = ST_UNDERFLOW;
				end else if ((op == CMD_POP_FRONT) != ring_reversed) begin
					ring_head  = ring_head + 1'b1;
					ring_count = ring_count - 1'b1;
				end else begin
					ring_count = ring_count - 1'b1;
				end
			end
			CMD_REVERSE: begin
				ring_reversed = !ring_reversed;
			end
			CMD_CLEAR: begin
				ring_count    = '0;
				ring_head     = '0;
				ring_reversed = 1'b0;
			end
			default: begin
			end
		endcase
		if (ring_count != 0) begin
			// count of CAPACITY wraps to zero in the low bits, so the tail lands right
			tail_pos   = ring_head + ring_count[HEAD_W-1:0] - 1'b1;
			first_word = ring_words[ring_head];
			last_word  = ring_words[tail_pos];
		end
		view.front = ring_reversed ? last_word : first_word;
		view.back  = ring_reversed ? first_word : last_word;
		view.occ   = ring_count;
		view.empty = (ring_count == 0);
		view.full  = (ring_count == CAPACITY);
		return view;
	endfunction

	task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Send one command beat and record its predicted result once accepted.
	task automatic send_command(input logic [CMD_W-1:0] op, input logic [WORD_BITS-1:0] word);
		while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - CMD_W - WORD_BITS){1'b0}}, word, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_views.push_back(apply_command(op, word));
		commands_sent++;
	endtask

	always @(posedge clk) begin : result_check
		deque_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_views.size() == 0) begin
				$display("%0t: result beat with no command pending, expected none, got %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				check_field("front_value", want.front, m_tdata[FRONT_LO +: FIELD_W]);
				check_field("back_value", want.back, m_tdata[BACK_LO +: FIELD_W]);
				check_field("occupancy", FIELD_W'(want.occ), FIELD_W'(m_tdata[OCC_LO +: OCC_W]));
				check_field("is_empty", FIELD_W'(want.empty), FIELD_W'(m_tdata[EMPTY_BIT]));
				check_field("is_full", FIELD_W'(want.full), FIELD_W'(m_tdata[FULL_BIT]));
				check_field("status", FIELD_W'(want.status),
					FIELD_W'(m_tdata[STATUS_LO +: ST_W]));
				views_checked++;
				underflows  += (want.status == ST_UNDERFLOW);
				overflows   += (want.status == ST_OVERFLOW);
				full_views  += want.full;
				empty_views += want.empty;
			end
		end
		m_tready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no beat moved for %0d cycles", $time, stall_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_empty_deque();
		send_command(CMD_QUERY, '0);
		send_command(CMD_POP_FRONT, '1);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_REVERSE, '1);
		send_command(CMD_UNDEFINED, 64'hDEAD_BEEF_0123_4567);
		send_command(CMD_REVERSE, '0);
		send_command(CMD_CLEAR, '1);
	endtask

	task automatic test_fill_and_overflow();
		send_command(CMD_PUSH_BACK, '0);
		send_command(CMD_PUSH_FRONT, '1);
		send_command(CMD_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
		send_command(CMD_PUSH_FRONT, 64'h5555_5555_5555_5555);
		for (int i = 4; i < CAPACITY; i++) begin
			send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, {$urandom, $urandom});
		end
		// full: both pushes must bounce
		send_command(CMD_PUSH_BACK, '1);
		send_command(CMD_PUSH_FRONT, '0);
		send_command(CMD_REVERSE, '0);
		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_PUSH_FRONT, 64'h8000_0000_0000_0001);
		send_command(CMD_CLEAR, '0);
	endtask

	// Random commands; phases lean toward pushes or pops so both full and empty are hit often.
	task automatic random_commands(input int unsigned total);
		int unsigned          push_bias;
		int unsigned          roll;
		logic [CMD_W-1:0]     op;
		logic [WORD_BITS-1:0] word;
		push_bias = 50;
		for (int unsigned n = 0; n < total; n++) begin
			if (n % 60 == 0) push_bias = $urandom_range(1) ? 80 : 20;
			roll = $urandom_range(99);
			if (roll < 1) op = CMD_CLEAR;
			else if (roll < 8) op = CMD_REVERSE;
			else if (roll < 12) op = CMD_QUERY;
			else if (roll < 13) op = CMD_UNDEFINED;
			else if ($urandom_range(99) < push_bias)
				op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
			case ($urandom_range(15))
				0:       word = '0;
				1:       word = '1;
				default: word = {$urandom, $urandom};
			endcase
			send_command(op, word);
		end
	endtask

	task automatic test_random_with_idling();
		idling_on = 1'b1;
		random_commands(1300);
	endtask

	task automatic test_back_to_back();
		idling_on = 1'b0;
		random_commands(320);
	endtask

	initial begin : run
		ring_head     = '0;
		ring_count    = '0;
		ring_reversed = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_deque();
		test_fill_and_overflow();
		test_random_with_idling();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d commands, checked %0d results: %0d underflows, %0d overflows,",
			commands_sent, views_checked, underflows, overflows);
		$display("%0d results at full, %0d empty, %0d mismatches.",
			full_views, empty_views, mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
